[src/stt_pkg.sv]
// Package for the scintillator timing trigger: widths, codes, event record,
// window limits and the alignment, slewing and weight tables.
// No dependencies.
`default_nettype none

package stt_pkg;

    localparam int CHANNELS_PER_SIDE = 32;
    localparam int ADC_BITS          = 10;
    localparam int AMP_DEPTH         = 1 << ADC_BITS;
    localparam int AMP_MAX           = AMP_DEPTH - 1;

    localparam int AMP_W   = 10;
    localparam int LT_W    = 16;
    localparam int SLEW_W  = 12;
    localparam int WGT_W   = 18;
    localparam int CT_W    = 19;
    localparam int PROD_W  = 38;
    localparam int SUM_W   = 48;
    localparam int WSUM_W  = 24;
    localparam int MT_W    = 18;
    localparam int T_W     = 50;
    localparam int OFS_W   = 16;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    localparam logic [1:0] DEC_EMPTY   = 2'd0;
    localparam logic [1:0] DEC_BB      = 2'd1;
    localparam logic [1:0] DEC_BG      = 2'd2;
    localparam logic [1:0] DEC_INVALID = 2'd3;

    localparam logic [1:0] SIDE_C = 2'd0;
    localparam logic [1:0] SIDE_A = 2'd1;

    localparam logic [1:0] CFG_TIME_OFFSET = 2'd0;
    localparam logic [1:0] CFG_SIM_MODE    = 2'd1;

    localparam logic signed [T_W-1:0] A_BB_LO = 50'sd19200;
    localparam logic signed [T_W-1:0] A_BB_HI = 50'sd21248;
    localparam logic signed [T_W-1:0] A_BG_LO = 50'sd13824;
    localparam logic signed [T_W-1:0] A_BG_HI = 50'sd14720;
    localparam logic signed [T_W-1:0] C_BB_LO = 50'sd19328;
    localparam logic signed [T_W-1:0] C_BB_HI = 50'sd20992;
    localparam logic signed [T_W-1:0] C_BG_LO = 50'sd17792;
    localparam logic signed [T_W-1:0] C_BG_HI = 50'sd18688;
    localparam logic signed [T_W-1:0] MT_POS  = 50'sd131071;
    localparam logic signed [T_W-1:0] MT_NEG  = -50'sd131072;

    typedef struct packed {
        logic signed [SUM_W-1:0] wt_sum;
        logic [WSUM_W-1:0]       w_sum;
        logic [1:0]              flag_dec;
        logic [1:0]              side;
    } evt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef logic signed [11:0] align_tab_t [64];
    typedef logic [SLEW_W-1:0]  slew_tab_t  [AMP_DEPTH];
    typedef logic [WGT_W-1:0]   wgt_tab_t   [AMP_DEPTH];

    localparam align_tab_t ALIGN_ROM = '{
        12'sd122, 12'sd23, 12'sd194, 12'sd53, 12'sd61, -12'sd47, 12'sd113, -12'sd72,
        12'sd67, 12'sd202, 12'sd250, 12'sd140, 12'sd127, 12'sd222, 12'sd169, 12'sd92,
        12'sd57, 12'sd136, 12'sd324, 12'sd341, 12'sd325, 12'sd453, 12'sd282, 12'sd163,
        12'sd550, 12'sd385, 12'sd408, 12'sd425, 12'sd299, 12'sd389, 12'sd378, 12'sd466,
        -12'sd497, -12'sd331, -12'sd553, -12'sd458, -12'sd796, -12'sd479, -12'sd404,
        -12'sd436, -12'sd464, -12'sd498, -12'sd648, -12'sd436, -12'sd533, -12'sd472,
        -12'sd156, -12'sd453,
        12'sd44, -12'sd15, 12'sd1, 12'sd102, 12'sd218, 12'sd68, 12'sd153, -12'sd41,
        12'sd150, 12'sd309, 12'sd237, 12'sd292, 12'sd165, 12'sd560, 12'sd432, 12'sd116
    };

    // elaboration-time math for the amplitude tables
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] log2_q16(input logic [63:0] a);
        int p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 0;
        frac = '0;
        while (p < 31 && (a >> (p + 1)) != 0) p++;
        m = a << (30 - p);
        for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | (64'd1 << k);
            end
        end
        return (64'(p) << 16) | frac;
    endfunction

    function automatic logic [63:0] pow_neg_q30(input logic [63:0] a, input logic [63:0] e);
        logic [63:0] roots [17];
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] g;
        logic [63:0] v;
        r = 64'd1 << 31;
        roots[0] = r;
        for (int k = 1; k <= 16; k++) begin
            r = isqrt64(r << 30);
            roots[k] = r;
        end
        y = (log2_q16(a) * e) >> 16;
        n = y >> 16;
        f = y & 64'hFFFF;
        if (f == 0) return (n > 30) ? 64'd0 : ((64'd1 << 30) >> n);
        if (n >= 30) return 64'd0;
        g = 64'h10000 - f;
        v = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            if (g[16 - k]) v = (v * roots[k]) >> 30;
        end
        return v >> (n + 1);
    endfunction

    function automatic slew_tab_t gen_slew();
        slew_tab_t t;
        logic [63:0] v;
        t[0] = '0;
        for (int a = 1; a < AMP_DEPTH; a++) begin
            v = (64'd4028 * pow_neg_q30(64'(a), 64'd27892) + (64'd1 << 29)) >> 30;
            t[a] = v[SLEW_W-1:0];
        end
        return t;
    endfunction

    function automatic wgt_tab_t gen_wgt();
        wgt_tab_t t;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        t[0] = '0;
        for (int a = 1; a < AMP_DEPTH; a++) begin
            d = 64'd105966765 * pow_neg_q30(64'(a), 64'd186857) + (64'd20891 << 30);
            num = (64'd1 << 62) + (d >> 1);
            rem = '0;
            q = '0;
            for (int i = 63; i >= 0; i--) begin
                rem = {rem[62:0], num[i]};
                if (rem >= d) begin
                    rem = rem - d;
                    q[i] = 1'b1;
                end
            end
            t[a] = q[WGT_W-1:0];
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[src/stt_front.sv]
// Front part: accepts channel requests, corrects and weights the hit time,
// accumulates the event sums and pushes a closed event into the queue.
// Depends on stt_pkg.
`default_nettype none

module stt_front (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [stt_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire                            s_tlast,
    input  stt_pkg::qstat_t                q_stat,
    output logic                           q_push,
    output stt_pkg::evt_t                  q_evt
);
    import stt_pkg::*;

    logic en;
    logic [ADC_BITS-1:0] rom_idx;
    localparam slew_tab_t SLEW_ROM = gen_slew();
    localparam wgt_tab_t  WGT_ROM  = gen_wgt();

    logic              s1_v_reg, s1_last_reg, s1_bb_reg, s1_bg_reg;
    logic [1:0]        s1_side_reg;
    logic [4:0]        s1_chan_reg;
    logic [LT_W-1:0]   s1_lt_reg;
    logic [SLEW_W-1:0] slew_q_reg;
    logic [WGT_W-1:0]  wgt_q_reg;

    logic                   s2_v_reg, s2_last_reg, s2_bb_reg, s2_bg_reg, s2_add_reg, s2_ok_reg;
    logic [1:0]             s2_side_reg;
    logic signed [CT_W-1:0] s2_ct_reg;
    logic [WGT_W-1:0]       s2_w_reg;

    logic                     s3_v_reg, s3_last_reg, s3_bb_reg, s3_bg_reg, s3_add_reg, s3_ok_reg;
    logic [1:0]               s3_side_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic [WGT_W-1:0]         s3_w_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [WSUM_W-1:0]       wsum_reg, wsum_next;
    logic [1:0]              fdec_reg, fdec_next;
    logic                    ffound_reg, ffound_next;

    logic                    s1_ok;
    logic signed [CT_W-1:0]  ct_next;
    logic signed [SUM_W:0]   sum_ext;
    logic [WSUM_W:0]         wsum_ext;

    assign en       = !(s3_v_reg && s3_last_reg && q_stat.full);
    assign s_tready = en;
    assign rom_idx  = (32'(s_tdata[32:23]) > AMP_MAX) ? ADC_BITS'(AMP_MAX)
                                                      : ADC_BITS'(s_tdata[32:23]);

    assign s1_ok   = (s1_side_reg <= SIDE_A) && (32'(s1_chan_reg) < CHANNELS_PER_SIDE);
    assign ct_next = CT_W'($signed({1'b0, s1_lt_reg}))
                   - CT_W'(ALIGN_ROM[{s1_side_reg[0], s1_chan_reg}])
                   - CT_W'($signed({1'b0, slew_q_reg}));

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= s_tdata[1:0];
            s1_chan_reg <= s_tdata[6:2];
            s1_lt_reg   <= s_tdata[22:7];
            s1_bb_reg   <= s_tdata[33];
            s1_bg_reg   <= s_tdata[34];
            s1_last_reg <= s_tlast;
            slew_q_reg  <= SLEW_ROM[rom_idx];
            wgt_q_reg   <= WGT_ROM[rom_idx];

            s2_side_reg <= s1_side_reg;
            s2_bb_reg   <= s1_bb_reg;
            s2_bg_reg   <= s1_bg_reg;
            s2_last_reg <= s1_last_reg;
            s2_ok_reg   <= s1_ok;
            s2_add_reg  <= s1_ok && (s1_lt_reg != '0);
            s2_ct_reg   <= ct_next;
            s2_w_reg    <= wgt_q_reg;

            s3_side_reg <= s2_side_reg;
            s3_bb_reg   <= s2_bb_reg;
            s3_bg_reg   <= s2_bg_reg;
            s3_last_reg <= s2_last_reg;
            s3_ok_reg   <= s2_ok_reg;
            s3_add_reg  <= s2_add_reg;
            s3_prod_reg <= s2_ct_reg * $signed({1'b0, s2_w_reg});
            s3_w_reg    <= s2_w_reg;
        end
    end

    always_comb begin
        sum_ext     = {sum_reg[SUM_W-1], sum_reg} + (SUM_W + 1)'(s3_prod_reg);
        wsum_ext    = {1'b0, wsum_reg} + (WSUM_W + 1)'(s3_w_reg);
        sum_next    = sum_reg;
        wsum_next   = wsum_reg;
        fdec_next   = fdec_reg;
        ffound_next = ffound_reg;
        if (s3_add_reg) begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                sum_next = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sum_next = sum_ext[SUM_W-1:0];
            end
            wsum_next = wsum_ext[WSUM_W] ? {WSUM_W{1'b1}} : wsum_ext[WSUM_W-1:0];
        end
        if (s3_ok_reg && !ffound_reg && (s3_bb_reg || s3_bg_reg)) begin
            fdec_next   = s3_bb_reg ? DEC_BB : DEC_BG;
            ffound_next = 1'b1;
        end
        q_push         = en && s3_v_reg && s3_last_reg;
        q_evt.wt_sum   = sum_next;
        q_evt.w_sum    = wsum_next;
        q_evt.flag_dec = fdec_next;
        q_evt.side     = s3_side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            sum_reg    <= '0;
            wsum_reg   <= '0;
            fdec_reg   <= DEC_EMPTY;
            ffound_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s_tvalid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            if (s3_v_reg) begin
                if (s3_last_reg) begin
                    sum_reg    <= '0;
                    wsum_reg   <= '0;
                    fdec_reg   <= DEC_EMPTY;
                    ffound_reg <= 1'b0;
                end else begin
                    sum_reg    <= sum_next;
                    wsum_reg   <= wsum_next;
                    fdec_reg   <= fdec_next;
                    ffound_reg <= ffound_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/stt_queue.sv]
// Two-entry event queue between the front and back parts.
// Depends on stt_pkg.
`default_nettype none

module stt_queue (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  stt_pkg::evt_t    push_evt,
    input  wire              pop,
    output stt_pkg::evt_t    pop_evt,
    output stt_pkg::qstat_t  stat
);
    import stt_pkg::*;

    evt_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_evt    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_evt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)      count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

[src/stt_back.sv]
// Back part: divides the event sums bit by bit, adds the offset, checks the
// side windows, or uses the flags in sim mode, and holds the result request
// for the output channel. Depends on stt_pkg.
`default_nettype none

module stt_back (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  stt_pkg::evt_t                      q_evt,
    input  stt_pkg::qstat_t                    q_stat,
    output logic                               q_pop,
    input  wire  signed [stt_pkg::OFS_W-1:0]   time_offset,
    input  wire                                sim_mode,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [stt_pkg::M_DATA_W-1:0]       m_tdata
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [SUM_W-1:0]      num_reg;
    logic [WSUM_W:0]       rem_reg;
    logic [WSUM_W-1:0]     div_reg;
    logic [5:0]            cnt_reg;
    logic                  neg_reg;
    logic [1:0]            side_reg, fdec_reg;
    logic                  out_v_reg;
    logic [M_DATA_W-1:0]   out_reg;

    logic [SUM_W-1:0]      mag;
    logic [WSUM_W:0]       rem_s;
    logic                  q_bit;
    logic signed [T_W-1:0] qs, t, t_out;
    logic [1:0]            dec;
    logic                  out_free;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
    assign out_free = !out_v_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign mag      = q_evt.wt_sum[SUM_W-1] ? SUM_W'(-q_evt.wt_sum) : SUM_W'(q_evt.wt_sum);
    assign rem_s    = {rem_reg[WSUM_W-1:0], num_reg[SUM_W-1]};
    assign q_bit    = rem_s >= {1'b0, div_reg};

    always_comb begin
        qs = T_W'({2'b00, num_reg});
        t  = (neg_reg ? -qs : qs) + T_W'(time_offset);
        t_out = t;
        if (sim_mode) begin
            dec = (side_reg <= SIDE_A) ? fdec_reg : DEC_EMPTY;
        end else if (side_reg > SIDE_A) begin
            dec   = DEC_INVALID;
            t_out = '0;
        end else if (side_reg == SIDE_A) begin
            if (t > A_BB_LO && t < A_BB_HI)      dec = DEC_BB;
            else if (t > A_BG_LO && t < A_BG_HI) dec = DEC_BG;
            else                                 dec = DEC_EMPTY;
        end else begin
            if (t > C_BB_LO && t < C_BB_HI)      dec = DEC_BB;
            else if (t > C_BG_LO && t < C_BG_HI) dec = DEC_BG;
            else                                 dec = DEC_EMPTY;
        end
        if (t_out > MT_POS)      t_out = MT_POS;
        else if (t_out < MT_NEG) t_out = MT_NEG;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) state_next = (q_evt.w_sum == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == 6'(SUM_W - 1)) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                neg_reg  <= q_evt.wt_sum[SUM_W-1];
                side_reg <= q_evt.side;
                fdec_reg <= q_evt.flag_dec;
                div_reg  <= q_evt.w_sum;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                num_reg  <= (q_evt.w_sum == '0) ? '0
                          : mag + SUM_W'(q_evt.w_sum >> 1);
            end
            ST_DIV: begin
                rem_reg <= q_bit ? rem_s - {1'b0, div_reg} : rem_s;
                num_reg <= {num_reg[SUM_W-2:0], q_bit};
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_FIN: begin
                if (out_free) out_reg <= {4'b0000, t_out[MT_W-1:0], dec};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) out_v_reg <= 1'b1;
            else if (m_tready)                   out_v_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[src/scintillator_timing_trigger.sv]
// Top level of the scintillator timing trigger: configuration registers,
// front part, event queue and back part. Depends on stt_pkg, stt_front,
// stt_queue and stt_back.
//
//  port group   dir  payload
//  s_*          in   tdata: side, channel, leading_time, amplitude, bb_flag, bg_flag; tlast: last
//  m_*          out  tdata: decision, mean_time
//  cfg_*        in   cfg_addr: register index, cfg_data: value
//
// Channels enter one per cycle while the input is not stalled. After its last
// channel is accepted, an event passes the three front stages, the event
// queue, the one-bit-per-cycle divider and the output register; a zero weight
// sum skips the divider. The back part takes one event at a time and pops the
// next only when it is idle again. Two closed events can wait in the queue;
// the input stalls only when a third is ready to close. Reset is synchronous,
// active low, and clears the sums, the queue and the configuration.
`default_nettype none

module scintillator_timing_trigger (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // side[1:0], channel[6:2], leading_time[22:7], amplitude[32:23],
    // bb_flag[33], bg_flag[34], zeros above
    input  wire  [stt_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire                            s_tlast,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // decision[1:0], mean_time[19:2], zeros above
    output logic [stt_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [1:0]                     cfg_addr,
    input  wire  [stt_pkg::OFS_W-1:0]      cfg_data
);
    import stt_pkg::*;

    logic signed [OFS_W-1:0] offset_reg;
    logic                    sim_reg;
    logic                    q_push, q_pop;
    evt_t                    push_evt, pop_evt;
    qstat_t                  q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            sim_reg    <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_addr == CFG_TIME_OFFSET) offset_reg <= cfg_data;
            if (cfg_addr == CFG_SIM_MODE)    sim_reg    <= cfg_data[0];
        end
    end

    stt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_evt    (push_evt)
    );

    stt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_evt (push_evt),
        .pop      (q_pop),
        .pop_evt  (pop_evt),
        .stat     (q_stat)
    );

    stt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_evt       (pop_evt),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .time_offset (offset_reg),
        .sim_mode    (sim_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == DEC_INVALID) |-> (m_tdata[19:2] == '0))
        else $error("invalid side result carries a nonzero mean");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_stat.full)
        else $error("input stalled while the event queue has room");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("event pushed into a full queue");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
